// ===== rtl/sid_pkg.sv =====
// ============================================================================
// sid_pkg
// Shared widths, character codes and types of the signed integer to
// decimal text converter.
// ============================================================================
package sid_pkg;

  localparam int VALUE_BITS  = 32;
  // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
  localparam int DEC_DIGITS  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS    = DEC_DIGITS * 4;
  localparam int DIG_IDX_W   = $clog2(DEC_DIGITS);
  localparam int REM_W       = $clog2(DEC_DIGITS + 1);

  // The converter shifts this many magnitude bits through the BCD register
  // per clock cycle.
  localparam int STEP_BITS   = 4;
  localparam int STEPS       = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS    = STEPS * STEP_BITS;
  localparam int STEP_CNT_W  = $clog2(STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [DEC_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  typedef struct packed {
    logic             neg;
    bcd_t             bcd;
    logic [REM_W-1:0] nsig;
  } digits_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_t;

endpackage

// ===== rtl/sid_value_if.sv =====
// ============================================================================
// sid_value_if
// Channel that carries one signed integer per transaction.
// ============================================================================
interface sid_value_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sid_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sid_char_if.sv =====
// ============================================================================
// sid_char_if
// Channel that carries one ASCII character per transaction.
// ============================================================================
interface sid_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== rtl/sid_front.sv =====
// ============================================================================
// sid_front
// Accepts integers and splits each into a sign and an unsigned magnitude.
// ============================================================================
module sid_front (
  sid_value_if.sink       number,
  output logic            push_valid,
  input  logic            push_ready,
  output sid_pkg::item_t  push_item
);

  logic [sid_pkg::VALUE_BITS-1:0] raw;

  assign raw          = number.value;
  assign number.ready = push_ready;
  assign push_valid   = number.valid;

  // Negation in unsigned arithmetic gives the right magnitude for the most
  // negative value as well.
  always_comb begin
    push_item.neg = raw[sid_pkg::VALUE_BITS-1];
    push_item.mag = push_item.neg ? (~raw + sid_pkg::VALUE_BITS'(1)) : raw;
  end

endmodule

// ===== rtl/sid_queue.sv =====
// ============================================================================
// sid_queue
// Short queue of classified items between the front and the converter.
// ============================================================================
module sid_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sid_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sid_pkg::item_t  pop_item
);

  sid_pkg::item_t                entries [sid_pkg::QUEUE_DEPTH];
  logic [sid_pkg::QPTR_W-1:0]    wr_ptr;
  logic [sid_pkg::QPTR_W-1:0]    rd_ptr;
  logic [sid_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != sid_pkg::QCNT_W'(sid_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sid_pkg::QPTR_W'(sid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sid_pkg::QPTR_W'(sid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sid_pkg::QCNT_W'(sid_pkg::QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on a pop");
`endif

endmodule

// ===== rtl/sid_convert.sv =====
// ============================================================================
// sid_convert
// Shift-and-add-3 binary to BCD converter, several magnitude bits a cycle.
// ============================================================================
module sid_convert (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sid_pkg::item_t    pop_item,
  output logic              dig_valid,
  input  logic              dig_ready,
  output sid_pkg::digits_t  dig
);

  localparam int WORK_BITS = sid_pkg::BCD_BITS + sid_pkg::PAD_BITS;

  sid_pkg::conv_state_t             state;
  sid_pkg::conv_state_t             state_next;
  logic                             neg;
  logic [sid_pkg::PAD_BITS-1:0]     mag;
  logic [sid_pkg::BCD_BITS-1:0]     bcd;
  logic [sid_pkg::STEP_CNT_W-1:0]   cnt;
  logic [WORK_BITS-1:0]             work_next;
  logic                             load;

  // One cycle of the converter: STEP_BITS rounds of correcting every BCD
  // digit that is five or more, then shifting one magnitude bit in.
  function automatic logic [WORK_BITS-1:0] dabble(input logic [WORK_BITS-1:0] w);
    logic [WORK_BITS-1:0] r;
    r = w;
    for (int s = 0; s < sid_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < sid_pkg::DEC_DIGITS; d++) begin
        if (r[sid_pkg::PAD_BITS + 4*d +: 4] >= 4'd5) begin
          r[sid_pkg::PAD_BITS + 4*d +: 4] = r[sid_pkg::PAD_BITS + 4*d +: 4] + 4'd3;
        end
      end
      r = r << 1;
    end
    return r;
  endfunction

  assign work_next = dabble({bcd, mag});

  always_comb begin
    state_next = state;
    unique case (state)
      sid_pkg::CONV_IDLE: begin
        if (pop_valid) state_next = sid_pkg::CONV_RUN;
      end
      sid_pkg::CONV_RUN: begin
        if (cnt == '0) state_next = sid_pkg::CONV_DONE;
      end
      sid_pkg::CONV_DONE: begin
        if (dig_ready) state_next = pop_valid ? sid_pkg::CONV_RUN : sid_pkg::CONV_IDLE;
      end
      default: state_next = sid_pkg::CONV_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    dig_valid = 1'b0;
    unique case (state)
      sid_pkg::CONV_IDLE: pop_ready = 1'b1;
      sid_pkg::CONV_RUN:  pop_ready = 1'b0;
      sid_pkg::CONV_DONE: begin
        dig_valid = 1'b1;
        pop_ready = dig_ready;
      end
      default: pop_ready = 1'b0;
    endcase
  end

  assign load = pop_valid && pop_ready;

  // Count of significant digits; zero still shows one digit.
  always_comb begin
    dig.neg  = neg;
    dig.bcd  = bcd;
    dig.nsig = sid_pkg::REM_W'(1);
    for (int d = 0; d < sid_pkg::DEC_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) dig.nsig = sid_pkg::REM_W'(d + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sid_pkg::CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= pop_item.neg;
      mag <= sid_pkg::PAD_BITS'(pop_item.mag);
      bcd <= '0;
      cnt <= sid_pkg::STEP_CNT_W'(sid_pkg::STEPS - 1);
    end else if (state == sid_pkg::CONV_RUN) begin
      {bcd, mag} <= work_next;
      cnt        <= cnt - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == sid_pkg::CONV_RUN && cnt == '0) |=> (state == sid_pkg::CONV_DONE))
    else $error("converter did not finish after its last step");
`endif

endmodule

// ===== rtl/sid_emit.sv =====
// ============================================================================
// sid_emit
// Serializes the sign and the significant BCD digits into ASCII characters
// through a registered output stage.
// ============================================================================
module sid_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              dig_valid,
  output logic              dig_ready,
  input  sid_pkg::digits_t  dig,
  sid_char_if.source        text
);

  sid_pkg::bcd_t                  bcd;
  logic [sid_pkg::REM_W-1:0]      rem;
  logic                           neg_pend;
  logic                           out_valid;
  logic [7:0]                     out_char;
  logic                           out_last;
  logic                           slot_free;
  logic                           busy;
  logic                           fire;
  logic                           last_fire;
  logic [sid_pkg::DIG_IDX_W-1:0]  idx;
  logic [3:0]                     cur_digit;

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last_char = out_last;

  assign slot_free = !out_valid || text.ready;
  assign busy      = (rem != '0);
  assign fire      = busy && slot_free;
  assign last_fire = fire && !neg_pend && (rem == sid_pkg::REM_W'(1));
  // The next number is taken in the cycle its predecessor's last digit leaves.
  assign dig_ready = !busy || last_fire;
  assign idx       = sid_pkg::DIG_IDX_W'(rem - 1'b1);
  assign cur_digit = bcd[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      neg_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) out_valid <= fire;
      if (dig_valid && dig_ready) begin
        rem      <= dig.nsig;
        neg_pend <= dig.neg;
      end else if (fire) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else begin
          rem <= rem - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char <= neg_pend ? sid_pkg::CHAR_MINUS : (sid_pkg::CHAR_ZERO + {4'd0, cur_digit});
      out_last <= !neg_pend && (rem == sid_pkg::REM_W'(1));
    end
    if (dig_valid && dig_ready) begin
      bcd <= dig.bcd;
    end
  end

`ifndef ASSERT_OFF
  a_sign_has_digits: assert property (@(posedge clk) disable iff (rst)
    neg_pend |-> busy)
    else $error("sign pending without digits to follow");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == sid_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as the final character");
`endif

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ============================================================================
// signed_int_to_decimal_ascii
// Converts signed integers into their decimal ASCII text, one character
// per output transaction.
// ============================================================================
// Usage:
//   number : one signed two's complement integer per transaction.
//   text   : the decimal text of each integer, most significant character
//            first, a '-' ahead of negative values, no leading zeros, and
//            last_char high on the final character of each number.
//   A transaction completes on a rising edge of clk with valid and ready high.
// Path: a number passes through the queue, the converter's eight
//   shift-and-add-3 steps, a hand-off and the registered output stage
//   before its first character is valid.
// Throughput: characters leave at one per cycle while text.ready is high.
//   The converter works on the next number while the current one is being
//   sent, so the sustained rate is set by the converter's eight steps and
//   the single-character output port.
// Reset: rst (synchronous, active high) empties the queue and drops any
//   number in flight; the block takes input again in the following cycle.
// Stall: while text.ready is low the output stage holds its character, the
//   converter holds a finished number, the queue fills, and number.ready
//   drops once two more numbers are waiting.
// ============================================================================
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  sid_value_if.sink   number,
  sid_char_if.source  text
);

  logic              push_valid;
  logic              push_ready;
  sid_pkg::item_t    push_item;
  logic              pop_valid;
  logic              pop_ready;
  sid_pkg::item_t    pop_item;
  logic              dig_valid;
  logic              dig_ready;
  sid_pkg::digits_t  dig;

  sid_front u_front (
    .number     (number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sid_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sid_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig)
  );

  sid_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig),
    .text       (text)
  );

endmodule
